// ===== design/tile_outer_product_accumulator_defines.svh =====
// assertion macros for the tile outer product accumulator
`ifndef TILE_OUTER_PRODUCT_ACCUMULATOR_DEFINES_SVH
`define TILE_OUTER_PRODUCT_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define TOPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("topa assertion failed");

`define TOPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("topa assertion failed");

`else

`define TOPA_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define TOPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/topa_pkg.sv =====
// shared types and constants for the tile outer product accumulator
package topa_pkg;

    localparam int TileRows = 16;
    localparam int TileCols = 16;
    localparam int FpW      = 32;
    localparam int RowW     = $clog2(TileRows);
    localparam int ColW     = $clog2(TileCols);
    localparam int RowBits  = TileCols * FpW;

    localparam logic [FpW-1:0] QNan = 32'h7FC0_0000;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_MAC  = 1'b1
    } command_t;

    typedef struct packed {
        logic               command;
        logic [RowBits-1:0] rhs;
        logic [FpW-1:0]     lhs_value;
        logic [RowW-1:0]    row_index;
        logic               end_of_tile;
    } item_t;

    typedef struct packed {
        logic [RowW-1:0]    out_row;
        logic [RowBits-1:0] sums;
        logic               last_row;
    } result_t;

    typedef struct packed {
        logic            load_rhs;
        logic            capture;
        logic            rd_en;
        logic [RowW-1:0] rd_row;
        logic            issue;
        logic [ColW-1:0] issue_col;
        logic            wr_en;
        logic            out_load;
        logic [RowW-1:0] out_row;
        logic            clear_rows;
    } dp_cmd_t;

    typedef struct packed {
        logic fma_valid;
        logic out_valid;
    } dp_status_t;

endpackage

// ===== design/topa_if.sv =====
// valid/ready channel interfaces for items and results
interface topa_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] rhs_pair_0;
    logic [63:0] rhs_pair_1;
    logic [63:0] rhs_pair_2;
    logic [63:0] rhs_pair_3;
    logic [63:0] rhs_pair_4;
    logic [63:0] rhs_pair_5;
    logic [63:0] rhs_pair_6;
    logic [63:0] rhs_pair_7;
    logic [31:0] lhs_value;
    logic [3:0]  row_index;
    logic        end_of_tile;

    modport source (
        output valid, command, rhs_pair_0, rhs_pair_1, rhs_pair_2, rhs_pair_3,
               rhs_pair_4, rhs_pair_5, rhs_pair_6, rhs_pair_7, lhs_value,
               row_index, end_of_tile,
        input  ready
    );

    modport sink (
        input  valid, command, rhs_pair_0, rhs_pair_1, rhs_pair_2, rhs_pair_3,
               rhs_pair_4, rhs_pair_5, rhs_pair_6, rhs_pair_7, lhs_value,
               row_index, end_of_tile,
        output ready
    );
endinterface

interface topa_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  out_row;
    logic [63:0] sum_pair_0;
    logic [63:0] sum_pair_1;
    logic [63:0] sum_pair_2;
    logic [63:0] sum_pair_3;
    logic [63:0] sum_pair_4;
    logic [63:0] sum_pair_5;
    logic [63:0] sum_pair_6;
    logic [63:0] sum_pair_7;
    logic        last_row;

    modport source (
        output valid, out_row, sum_pair_0, sum_pair_1, sum_pair_2, sum_pair_3,
               sum_pair_4, sum_pair_5, sum_pair_6, sum_pair_7, last_row,
        input  ready
    );

    modport sink (
        input  valid, out_row, sum_pair_0, sum_pair_1, sum_pair_2, sum_pair_3,
               sum_pair_4, sum_pair_5, sum_pair_6, sum_pair_7, last_row,
        output ready
    );
endinterface

// ===== design/topa_fma.sv =====
// eight-stage pipelined fp32 fused multiply-add, round to nearest even
module topa_fma (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [topa_pkg::ColW-1:0] in_tag,
    input  logic [31:0]               a,
    input  logic [31:0]               b,
    input  logic [31:0]               c,
    output logic                      out_valid,
    output logic [topa_pkg::ColW-1:0] out_tag,
    output logic [31:0]               result
);

    function automatic logic [5:0] msb_pos(input logic [63:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    logic [7:0]                valid_reg;
    logic [topa_pkg::ColW-1:0] tag_reg [8];
    logic                      spec_reg [7];
    logic [31:0]               spec_val_reg [7];

    // stage 1: special cases and mantissa product
    logic        sa, sb, sc, sp;
    logic [7:0]  ea, eb, ec;
    logic [22:0] fa, fb, fc;
    logic        ia, ib, ic;
    logic [23:0] ma, mb, mc;
    logic        s1_spec;
    logic [31:0] s1_val;

    assign sa = a[31];
    assign sb = b[31];
    assign sc = c[31];
    assign sp = sa ^ sb;
    assign ea = a[30:23];
    assign eb = b[30:23];
    assign ec = c[30:23];
    assign fa = a[22:0];
    assign fb = b[22:0];
    assign fc = c[22:0];
    assign ia = (ea == 8'hFF);
    assign ib = (eb == 8'hFF);
    assign ic = (ec == 8'hFF);
    assign ma = {|ea, fa};
    assign mb = {|eb, fb};
    assign mc = {|ec, fc};

    always_comb
    begin
        s1_spec = 1'b1;
        s1_val  = topa_pkg::QNan;
        priority if ((ia && (fa != '0)) || (ib && (fb != '0)) || (ic && (fc != '0)))
        begin
            s1_val = topa_pkg::QNan;
        end
        else if (ia || ib)
        begin
            if ((ma == '0) || (mb == '0) || (ic && (sc != sp)))
            begin
                s1_val = topa_pkg::QNan;
            end
            else
            begin
                s1_val = {sp, 8'hFF, 23'd0};
            end
        end
        else if (ic)
        begin
            s1_val = c;
        end
        else if ((ma == '0) || (mb == '0))
        begin
            s1_val = (mc == '0) ? {sp & sc, 31'd0} : c;
        end
        else
        begin
            s1_spec = 1'b0;
        end
    end

    logic signed [11:0] la, lb, lc;
    assign la = $signed({4'd0, (ea == '0) ? 8'd1 : ea}) - 12'sd150;
    assign lb = $signed({4'd0, (eb == '0) ? 8'd1 : eb}) - 12'sd150;
    assign lc = $signed({4'd0, (ec == '0) ? 8'd1 : ec}) - 12'sd150;

    logic [47:0]        s1_mp_reg;
    logic [23:0]        s1_mc_reg;
    logic signed [11:0] s1_lp_reg, s1_lc_reg;
    logic               s1_sp_reg, s1_sc_reg;

    // stage 2: leading-one positions
    logic [47:0]        s2_mp_reg;
    logic [23:0]        s2_mc_reg;
    logic [5:0]         s2_pos_p_reg, s2_pos_c_reg;
    logic signed [11:0] s2_lp_reg, s2_lc_reg;
    logic               s2_sp_reg, s2_sc_reg;

    // stage 3: normalize both operands to bit 61
    logic [5:0]         s3_sh_p, s3_sh_c;
    logic [63:0]        s3_np_reg, s3_nc_reg;
    logic signed [11:0] s3_tp_reg, s3_tc_reg;
    logic               s3_sp_reg, s3_sc_reg, s3_czero_reg;

    assign s3_sh_p = 6'd61 - s2_pos_p_reg;
    assign s3_sh_c = 6'd61 - s2_pos_c_reg;

    // stage 4: swap and align
    logic               s4_pbig;
    logic [63:0]        s4_nb, s4_ns, s4_sm;
    logic signed [11:0] s4_tb, s4_ts, s4_d;
    logic               s4_sbig, s4_ssmall;
    logic [63:0]        s4_nb_reg, s4_sm_reg;
    logic signed [11:0] s4_t_reg;
    logic               s4_sbig_reg, s4_ssmall_reg;

    always_comb
    begin
        s4_pbig   = (s3_tp_reg >= s3_tc_reg) || s3_czero_reg;
        s4_nb     = s4_pbig ? s3_np_reg : s3_nc_reg;
        s4_tb     = s4_pbig ? s3_tp_reg : s3_tc_reg;
        s4_sbig   = s4_pbig ? s3_sp_reg : s3_sc_reg;
        s4_ns     = s4_pbig ? s3_nc_reg : s3_np_reg;
        s4_ts     = s4_pbig ? s3_tc_reg : s3_tp_reg;
        s4_ssmall = s4_pbig ? s3_sc_reg : s3_sp_reg;
        s4_d      = s4_tb - s4_ts;
        if (s3_czero_reg)
        begin
            s4_sm     = '0;
            s4_ssmall = s3_sp_reg;
        end
        else if (s4_d >= 12'sd64)
        begin
            s4_sm = 64'd1;
        end
        else
        begin
            s4_sm = s4_ns >> s4_d[5:0];
            if ((s4_ns & ~({64{1'b1}} << s4_d[5:0])) != '0)
            begin
                s4_sm[0] = 1'b1;
            end
        end
    end

    // stage 5: add or subtract
    logic [63:0]        s5_r;
    logic               s5_sign;
    logic [63:0]        s5_r_reg;
    logic signed [11:0] s5_t_reg;
    logic               s5_sign_reg;

    always_comb
    begin
        if (s4_sbig_reg == s4_ssmall_reg)
        begin
            s5_r    = s4_nb_reg + s4_sm_reg;
            s5_sign = s4_sbig_reg;
        end
        else if (s4_nb_reg >= s4_sm_reg)
        begin
            s5_r    = s4_nb_reg - s4_sm_reg;
            s5_sign = s4_sbig_reg;
        end
        else
        begin
            s5_r    = s4_sm_reg - s4_nb_reg;
            s5_sign = s4_ssmall_reg;
        end
    end

    // stage 6: leading-one position of the sum
    logic [63:0]        s6_r_reg;
    logic [5:0]         s6_pos_reg;
    logic signed [11:0] s6_t_reg;
    logic               s6_sign_reg;

    // stage 7: target exponent and left or right shift
    logic signed [11:0] s7_target, s7_s, s7_neg;
    logic [63:0]        s7_q;
    logic               s7_half, s7_rest;
    logic [5:0]         s7_sm1;
    logic [24:0]        s7_q_reg;
    logic               s7_half_reg, s7_rest_reg, s7_sign_reg;
    logic signed [11:0] s7_target_reg;

    always_comb
    begin
        s7_target = $signed({6'd0, s6_pos_reg}) + s6_t_reg - 12'sd23;
        if (s7_target < -12'sd149)
        begin
            s7_target = -12'sd149;
        end
        s7_s    = s7_target - s6_t_reg;
        s7_neg  = -s7_s;
        s7_sm1  = 6'(s7_s - 12'sd1);
        s7_half = 1'b0;
        s7_rest = 1'b0;
        if (s7_s <= 12'sd0)
        begin
            s7_q = s6_r_reg << s7_neg[5:0];
        end
        else if (s7_s >= 12'sd64)
        begin
            s7_q = '0;
        end
        else
        begin
            s7_q    = s6_r_reg >> s7_s[5:0];
            s7_half = s6_r_reg[s7_sm1];
            s7_rest = (s6_r_reg & ~({64{1'b1}} << s7_sm1)) != '0;
        end
    end

    // stage 8: round, renormalize, pack
    logic [24:0]        s8_q;
    logic signed [11:0] s8_target, s8_biased;
    logic [31:0]        s8_res;

    always_comb
    begin
        s8_q      = s7_q_reg + {24'd0, s7_half_reg && (s7_rest_reg || s7_q_reg[0])};
        s8_target = s7_target_reg;
        if (s8_q[24])
        begin
            s8_q      = s8_q >> 1;
            s8_target = s8_target + 12'sd1;
        end
        s8_biased = s8_target + 12'sd149;
        if (s8_biased >= 12'sd254)
        begin
            s8_res = {s7_sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            s8_res = {s7_sign_reg, 31'd0} + {1'b0, s8_biased[7:0], 23'd0}
                   + {8'd0, s8_q[23:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0]      <= in_tag;
        spec_reg[0]     <= s1_spec;
        spec_val_reg[0] <= s1_val;
        for (int i = 1; i < 8; i++)
        begin
            tag_reg[i] <= tag_reg[i-1];
        end
        for (int i = 1; i < 7; i++)
        begin
            spec_reg[i]     <= spec_reg[i-1];
            spec_val_reg[i] <= spec_val_reg[i-1];
        end
        // an exact zero sum becomes a positive zero
        if (!spec_reg[3] && (s5_r == '0))
        begin
            spec_reg[4]     <= 1'b1;
            spec_val_reg[4] <= '0;
        end

        s1_mp_reg <= 48'(ma) * 48'(mb);
        s1_mc_reg <= mc;
        s1_lp_reg <= la + lb;
        s1_lc_reg <= lc;
        s1_sp_reg <= sp;
        s1_sc_reg <= sc;

        s2_mp_reg    <= s1_mp_reg;
        s2_mc_reg    <= s1_mc_reg;
        s2_pos_p_reg <= msb_pos({16'd0, s1_mp_reg});
        s2_pos_c_reg <= msb_pos({40'd0, s1_mc_reg});
        s2_lp_reg    <= s1_lp_reg;
        s2_lc_reg    <= s1_lc_reg;
        s2_sp_reg    <= s1_sp_reg;
        s2_sc_reg    <= s1_sc_reg;

        s3_np_reg    <= {16'd0, s2_mp_reg} << s3_sh_p;
        s3_nc_reg    <= {40'd0, s2_mc_reg} << s3_sh_c;
        s3_tp_reg    <= s2_lp_reg - $signed({6'd0, s3_sh_p});
        s3_tc_reg    <= s2_lc_reg - $signed({6'd0, s3_sh_c});
        s3_sp_reg    <= s2_sp_reg;
        s3_sc_reg    <= s2_sc_reg;
        s3_czero_reg <= (s2_mc_reg == '0);

        s4_nb_reg     <= s4_nb;
        s4_sm_reg     <= s4_sm;
        s4_t_reg      <= s4_tb;
        s4_sbig_reg   <= s4_sbig;
        s4_ssmall_reg <= s4_ssmall;

        s5_r_reg    <= s5_r;
        s5_t_reg    <= s4_t_reg;
        s5_sign_reg <= s5_sign;

        s6_r_reg    <= s5_r_reg;
        s6_pos_reg  <= msb_pos(s5_r_reg);
        s6_t_reg    <= s5_t_reg;
        s6_sign_reg <= s5_sign_reg;

        s7_q_reg      <= s7_q[24:0];
        s7_half_reg   <= s7_half;
        s7_rest_reg   <= s7_rest;
        s7_sign_reg   <= s6_sign_reg;
        s7_target_reg <= s7_target;

        result <= spec_reg[6] ? spec_val_reg[6] : s8_res;
    end

    assign out_valid = valid_reg[7];
    assign out_tag   = tag_reg[7];

endmodule

// ===== design/topa_datapath.sv =====
// operand registers, accumulator row memory, shared fma and output register
module topa_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  topa_pkg::item_t      item,
    input  topa_pkg::dp_cmd_t    cmd,
    input  logic                 out_ready,
    output topa_pkg::dp_status_t status,
    output topa_pkg::result_t    result
);

    logic [topa_pkg::FpW-1:0]     rhs_reg [topa_pkg::TileCols];
    logic [topa_pkg::FpW-1:0]     lhs_reg;
    logic [topa_pkg::RowW-1:0]    row_reg;
    logic [topa_pkg::RowBits-1:0] acc_mem [topa_pkg::TileRows];
    logic [topa_pkg::TileRows-1:0] row_valid_reg;
    logic [topa_pkg::RowBits-1:0] rd_data_reg;
    logic                         rd_valid_reg;
    logic [topa_pkg::RowBits-1:0] acc_row;
    logic [topa_pkg::FpW-1:0]     res_buf [topa_pkg::TileCols];
    logic [topa_pkg::RowBits-1:0] res_row;
    logic                         out_valid_reg;
    topa_pkg::result_t            out_reg;
    logic                         fma_valid;
    logic [topa_pkg::ColW-1:0]    fma_tag;
    logic [topa_pkg::FpW-1:0]     fma_result;

    // rows never written since the last tile read as positive zero
    assign acc_row = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        for (int j = 0; j < topa_pkg::TileCols; j++)
        begin
            res_row[j*topa_pkg::FpW +: topa_pkg::FpW] = res_buf[j];
        end
    end

    topa_fma u_fma (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.issue),
        .in_tag    (cmd.issue_col),
        .a         (rhs_reg[cmd.issue_col]),
        .b         (lhs_reg),
        .c         (acc_row[cmd.issue_col*topa_pkg::FpW +: topa_pkg::FpW]),
        .out_valid (fma_valid),
        .out_tag   (fma_tag),
        .result    (fma_result)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_rhs)
        begin
            for (int j = 0; j < topa_pkg::TileCols; j++)
            begin
                rhs_reg[j] <= item.rhs[j*topa_pkg::FpW +: topa_pkg::FpW];
            end
        end
        if (cmd.capture)
        begin
            lhs_reg <= item.lhs_value;
            row_reg <= item.row_index;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg  <= acc_mem[cmd.rd_row];
            rd_valid_reg <= row_valid_reg[cmd.rd_row];
        end
        if (cmd.wr_en)
        begin
            acc_mem[row_reg] <= res_row;
        end
        if (fma_valid)
        begin
            res_buf[fma_tag] <= fma_result;
        end
        if (cmd.out_load)
        begin
            out_reg.out_row  <= cmd.out_row;
            out_reg.sums     <= acc_row;
            out_reg.last_row <= (cmd.out_row == topa_pkg::RowW'(topa_pkg::TileRows - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_rows)
            begin
                row_valid_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                row_valid_reg[row_reg] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.fma_valid = fma_valid;
    assign status.out_valid = out_valid_reg;
    assign result           = out_reg;

endmodule

// ===== design/topa_ctrl.sv =====
// sequencer for row loads, column issue, write back and tile emission
module topa_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  topa_pkg::command_t        in_command,
    input  logic [topa_pkg::RowW-1:0] in_row,
    input  logic                      in_eot,
    input  logic                      out_ready,
    input  topa_pkg::dp_status_t      status,
    output logic                      in_ready,
    output topa_pkg::dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_WRITE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    localparam logic [topa_pkg::ColW-1:0] LastCol = topa_pkg::ColW'(topa_pkg::TileCols - 1);
    localparam logic [topa_pkg::RowW-1:0] LastRow = topa_pkg::RowW'(topa_pkg::TileRows - 1);

    state_t                    state_reg, state_next;
    logic [topa_pkg::ColW-1:0] col_reg, col_next;
    logic [topa_pkg::ColW-1:0] cnt_reg, cnt_next;
    logic [topa_pkg::RowW-1:0] emit_reg, emit_next;
    logic                      eot_reg, eot_next;
    logic                      out_xfer;

    assign out_xfer = status.out_valid && out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        cnt_next   = status.fma_valid ? cnt_reg + 1'b1 : cnt_reg;
        emit_next  = emit_reg;
        eot_next   = eot_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_command == topa_pkg::CMD_LOAD))
                begin
                    cmd.load_rhs = 1'b1;
                end
                else if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_row  = in_row;
                    eot_next    = in_eot;
                    col_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue     = 1'b1;
                cmd.issue_col = col_reg;
                col_next      = col_reg + 1'b1;
                if (col_reg == LastCol)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.fma_valid && (cnt_reg == LastCol))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                emit_next  = '0;
                state_next = eot_reg ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_row = emit_reg;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                cmd.out_load = 1'b1;
                cmd.out_row  = emit_reg;
                state_next   = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_xfer && (emit_reg == LastRow))
                begin
                    cmd.clear_rows = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (out_xfer)
                begin
                    emit_next  = emit_reg + 1'b1;
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            cnt_reg   <= '0;
            emit_reg  <= '0;
            eot_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            emit_reg  <= emit_next;
            eot_reg   <= eot_next;
        end
    end

endmodule

// ===== design/tile_outer_product_accumulator.sv =====
// top level of the tile outer product accumulator
// load item: right-hand row captured; multiply item: row read, 16 column issues
// into the one shared 8-stage fma, then write back of the row
// end of tile: 16 result transfers after the multiply; each row waits until taken
// reset: asynchronous active low; all accumulator rows read as +0 right after reset
// right-hand row holds no defined value until the first load
`include "tile_outer_product_accumulator_defines.svh"

module tile_outer_product_accumulator (
    input logic        clk,
    input logic        rst_n,
    topa_in_if.sink    items,
    topa_out_if.source results
);

    topa_pkg::item_t      item;
    topa_pkg::result_t    res;
    topa_pkg::dp_cmd_t    cmd;
    topa_pkg::dp_status_t status;
    logic                 in_ready;
    logic                 last_xfer;
    logic                 row_is_last;

    assign item.command     = items.command;
    assign item.rhs         = {items.rhs_pair_7, items.rhs_pair_6, items.rhs_pair_5,
                               items.rhs_pair_4, items.rhs_pair_3, items.rhs_pair_2,
                               items.rhs_pair_1, items.rhs_pair_0};
    assign item.lhs_value   = items.lhs_value;
    assign item.row_index   = items.row_index;
    assign item.end_of_tile = items.end_of_tile;

    topa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (items.valid),
        .in_command (topa_pkg::command_t'(items.command)),
        .in_row     (items.row_index),
        .in_eot     (items.end_of_tile),
        .out_ready  (results.ready),
        .status     (status),
        .in_ready   (in_ready),
        .cmd        (cmd)
    );

    topa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .out_ready (results.ready),
        .status    (status),
        .result    (res)
    );

    assign items.ready        = in_ready;
    assign results.valid      = status.out_valid;
    assign results.out_row    = res.out_row;
    assign results.sum_pair_0 = res.sums[63:0];
    assign results.sum_pair_1 = res.sums[127:64];
    assign results.sum_pair_2 = res.sums[191:128];
    assign results.sum_pair_3 = res.sums[255:192];
    assign results.sum_pair_4 = res.sums[319:256];
    assign results.sum_pair_5 = res.sums[383:320];
    assign results.sum_pair_6 = res.sums[447:384];
    assign results.sum_pair_7 = res.sums[511:448];
    assign results.last_row   = res.last_row;

    assign last_xfer   = results.valid && results.ready && results.last_row;
    assign row_is_last = (results.out_row == topa_pkg::RowW'(topa_pkg::TileRows - 1));

    `TOPA_ASSERT_SAME(a_no_accept_while_emitting, clk, rst_n, items.ready, !results.valid)
    `TOPA_ASSERT_NEXT(a_idle_after_last_row, clk, rst_n, last_xfer, items.ready)
    `TOPA_ASSERT_SAME(a_last_row_index, clk, rst_n, results.valid, results.last_row == row_is_last)

endmodule

// ===== tb/sv/topa_tb_pkg.sv =====
`timescale 1ns / 1ps
// tile predictor and result scoreboard for the tile outer product accumulator testbench
package topa_tb_pkg;
    import topa_pkg::*;

    typedef struct {
        logic [RowW-1:0]    row;
        logic [RowBits-1:0] sums;
        logic               last;
    } tile_row_t;

    function automatic int msb_pos(bit [63:0] v);
        int p;
        p = 63;
        while (p > 0 && !v[p])
            p--;
        return p;
    endfunction

    // binary32 a*b+c, one rounding, nearest even
    function automatic logic [FpW-1:0] fma_rne(logic [FpW-1:0] a, logic [FpW-1:0] b,
                                               logic [FpW-1:0] c);
        bit sa, sb, sc, sp, ia, ib, ic, sign, sbig, ssmall;
        bit [7:0] ea, eb, ec;
        bit [22:0] fa, fb, fc;
        bit [63:0] ma, mb, mc, mp, np, nc, nb, ns, sm, r, q, half, rest;
        int la, lb, lc, lp, tp, tc, tb, ts, t, d, target, s, pos;
        logic [FpW-1:0] res;
        sa = a[31]; sb = b[31]; sc = c[31]; sp = sa ^ sb;
        ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
        fa = a[22:0]; fb = b[22:0]; fc = c[22:0];
        ia = ea == 8'hFF; ib = eb == 8'hFF; ic = ec == 8'hFF;
        if ((ia && fa != 0) || (ib && fb != 0) || (ic && fc != 0))
            return QNan;
        if (ia || ib)
        begin
            if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0))
                return QNan;
            if (ic && sc != sp)
                return QNan;
            return {sp, 31'h7F80_0000};
        end
        if (ic)
            return c;
        ma = ea != 0 ? {41'd1, fa} : {41'd0, fa};
        mb = eb != 0 ? {41'd1, fb} : {41'd0, fb};
        mc = ec != 0 ? {41'd1, fc} : {41'd0, fc};
        la = (ea != 0 ? int'(ea) : 1) - 150;
        lb = (eb != 0 ? int'(eb) : 1) - 150;
        lc = (ec != 0 ? int'(ec) : 1) - 150;
        mp = ma * mb;
        lp = la + lb;
        if (mp == 0)
        begin
            if (mc == 0)
                return {sp & sc, 31'd0};
            return c;
        end
        pos = msb_pos(mp);
        np = mp << (61 - pos);
        tp = lp - (61 - pos);
        if (mc == 0)
        begin
            r = np;
            t = tp;
            sign = sp;
        end
        else
        begin
            pos = msb_pos(mc);
            nc = mc << (61 - pos);
            tc = lc - (61 - pos);
            if (tp >= tc)
            begin
                nb = np; tb = tp; sbig = sp; ns = nc; ts = tc; ssmall = sc;
            end
            else
            begin
                nb = nc; tb = tc; sbig = sc; ns = np; ts = tp; ssmall = sp;
            end
            d = tb - ts;
            if (d >= 64)
                sm = 1;
            else
            begin
                sm = ns >> d;
                if ((ns & ((64'd1 << d) - 1)) != 0)
                    sm[0] = 1'b1;
            end
            t = tb;
            if (sbig == ssmall)
            begin
                r = nb + sm;
                sign = sbig;
            end
            else if (nb >= sm)
            begin
                r = nb - sm;
                sign = sbig;
            end
            else
            begin
                r = sm - nb;
                sign = ssmall;
            end
            if (r == 0)
                return '0;
        end
        pos = msb_pos(r);
        target = pos + t - 23;
        if (target < -149)
            target = -149;
        s = target - t;
        if (s <= 0)
            q = r << (-s);
        else if (s >= 64)
            q = 0;
        else
        begin
            q = r >> s;
            half = (r >> (s - 1)) & 64'd1;
            rest = r & ((64'd1 << (s - 1)) - 1);
            if (half != 0 && (rest != 0 || q[0]))
                q++;
            if ((q >> 24) != 0)
            begin
                q >>= 1;
                target++;
            end
        end
        if (target + 149 >= 254)
            return {sign, 31'h7F80_0000};
        res = ({31'd0, sign} << 31) + (32'(target + 149) << 23) + q[31:0];
        return res;
    endfunction

    class tile_scoreboard;
        logic [FpW-1:0] acc[TileRows*TileCols];
        logic [FpW-1:0] rhs_cols[TileCols];
        tile_row_t      expected_rows[$];
        int             errors;

        function new();
            foreach (acc[i])
                acc[i] = '0;
            foreach (rhs_cols[i])
                rhs_cols[i] = '0;
            errors = 0;
        endfunction

        function void note_item(logic command, logic [RowBits-1:0] rhs,
                                logic [FpW-1:0] lhs, logic [RowW-1:0] row, logic eot);
            tile_row_t tr;
            if (command == CMD_LOAD)
            begin
                foreach (rhs_cols[j])
                    rhs_cols[j] = rhs[j*FpW +: FpW];
                return;
            end
            for (int j = 0; j < TileCols; j++)
                acc[row*TileCols+j] = fma_rne(rhs_cols[j], lhs, acc[row*TileCols+j]);
            if (!eot)
                return;
            for (int i = 0; i < TileRows; i++)
            begin
                tr.row  = RowW'(i);
                tr.last = i == TileRows - 1;
                for (int j = 0; j < TileCols; j++)
                begin
                    tr.sums[j*FpW +: FpW] = acc[i*TileCols+j];
                    acc[i*TileCols+j] = '0;
                end
                expected_rows.push_back(tr);
            end
        endfunction

        function void check_row(logic [RowW-1:0] row, logic [RowBits-1:0] sums, logic last);
            tile_row_t tr;
            if (expected_rows.size() == 0)
            begin
                $display("%0t unexpected result row %0d", $time, row);
                errors++;
                return;
            end
            tr = expected_rows.pop_front();
            if (row !== tr.row)
            begin
                $display("%0t out_row expected %h actual %h", $time, tr.row, row);
                errors++;
            end
            if (last !== tr.last)
            begin
                $display("%0t last_row expected %h actual %h", $time, tr.last, last);
                errors++;
            end
            for (int k = 0; k < TileCols / 2; k++)
                if (sums[k*64 +: 64] !== tr.sums[k*64 +: 64])
                begin
                    $display("%0t row %0d sum_pair_%0d expected %h actual %h", $time, tr.row,
                             k, tr.sums[k*64 +: 64], sums[k*64 +: 64]);
                    errors++;
                end
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction
    endclass
endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// top level testbench for the tile outer product accumulator
module tb_top;
    import topa_pkg::*;
    import topa_tb_pkg::*;

    localparam int IdlePct    = 37;
    localparam int StallLimit = 5000;

    logic clk;
    logic rst_n;
    logic steady;
    int   stalled;
    int   sent;

    topa_in_if  items();
    topa_out_if results();

    tile_scoreboard sb;

    tile_outer_product_accumulator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [FpW-1:0] rand_fp();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return {1'($urandom), 8'($urandom_range(112, 140)), 23'($urandom)};
        if (pick < 82)
            return $urandom;
        case ($urandom_range(0, 7))
            0: return {1'($urandom), 31'd0};
            1: return {1'($urandom), 8'd0, 23'($urandom)};
            2: return {1'($urandom), 31'h7F80_0000};
            3: return {1'($urandom), 8'hFF, 23'($urandom | 1)};
            4: return {1'($urandom), 31'h7F7F_FFFF};
            5: return {1'($urandom), 31'h0080_0000};
            6: return {1'($urandom), 8'($urandom_range(240, 254)), 23'($urandom)};
            default: return {1'($urandom), 8'($urandom_range(1, 30)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [RowBits-1:0] rand_rhs();
        logic [RowBits-1:0] v;
        for (int j = 0; j < TileCols; j++)
            v[j*FpW +: FpW] = rand_fp();
        return v;
    endfunction

    task automatic send(logic command, logic [RowBits-1:0] rhs, logic [FpW-1:0] lhs,
                        logic [RowW-1:0] row, logic eot);
        while (!steady && $urandom_range(0, 99) < IdlePct)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid       <= 1'b1;
        items.command     <= command;
        items.rhs_pair_0  <= rhs[0*64 +: 64];
        items.rhs_pair_1  <= rhs[1*64 +: 64];
        items.rhs_pair_2  <= rhs[2*64 +: 64];
        items.rhs_pair_3  <= rhs[3*64 +: 64];
        items.rhs_pair_4  <= rhs[4*64 +: 64];
        items.rhs_pair_5  <= rhs[5*64 +: 64];
        items.rhs_pair_6  <= rhs[6*64 +: 64];
        items.rhs_pair_7  <= rhs[7*64 +: 64];
        items.lhs_value   <= lhs;
        items.row_index   <= row;
        items.end_of_tile <= eot;
        do
            @(posedge clk);
        while (!items.ready);
        sent++;
    endtask

    task automatic load(logic [RowBits-1:0] rhs, logic eot);
        send(CMD_LOAD, rhs, $urandom, 4'($urandom), eot);
    endtask

    task automatic mac(logic [FpW-1:0] lhs, logic [RowW-1:0] row, logic eot);
        send(CMD_MAC, {16{32'($urandom)}}, lhs, row, eot);
    endtask

    task automatic directed_items();
        logic [RowBits-1:0] specials;
        specials = {32'hFFFF_FFFF, 32'h3FC0_0000, 32'h4000_0000, 32'h8000_0001,
                    32'hBF80_0000, 32'h3F80_0000, 32'h7F7F_FFFF, 32'h0080_0000,
                    32'h007F_FFFF, 32'h0000_0001, 32'h7F80_0001, 32'h7FC0_0000,
                    32'hFF80_0000, 32'h7F80_0000, 32'h8000_0000, 32'h0000_0000};
        load(specials, 1'b1);
        mac(32'h0000_0000, 4'd0, 1'b0);
        mac(32'h8000_0000, 4'd1, 1'b0);
        mac(32'h3F80_0000, 4'd2, 1'b0);
        mac(32'hBF80_0000, 4'd2, 1'b0);
        mac(32'h7F80_0000, 4'd3, 1'b0);
        mac(32'hFF80_0000, 4'd3, 1'b0);
        mac(32'h7FC0_0000, 4'd4, 1'b0);
        mac(32'h7F7F_FFFF, 4'd5, 1'b0);
        mac(32'h7F7F_FFFF, 4'd5, 1'b0);
        mac(32'h0000_0001, 4'd6, 1'b0);
        mac(32'h3400_0000, 4'd7, 1'b0);
        mac(32'hFFFF_FFFF, 4'd15, 1'b0);
        load({16{32'h3F80_0000}}, 1'b0);
        mac(32'h3F80_0000, 4'd8, 1'b0);
        mac(32'hBF80_0000, 4'd8, 1'b0);
        load({16{32'h8000_0000}}, 1'b0);
        mac(32'h3F80_0000, 4'd9, 1'b0);
        mac(32'h0080_0000, 4'd10, 1'b0);
        load({16{32'h0080_0000}}, 1'b0);
        mac(32'hBF00_0000, 4'd10, 1'b0);
        mac(32'h3F80_0001, 4'd11, 1'b1);
    endtask

    task automatic random_items(int count);
        int stop;
        stop = sent + count;
        load(rand_rhs(), 1'($urandom));
        while (sent < stop)
        begin
            steady = sent > stop - count / 2 && sent < stop - count / 4;
            if ($urandom_range(0, 99) < 20)
                load(rand_rhs(), 1'($urandom));
            else
                mac(rand_fp(), 4'($urandom), $urandom_range(0, 99) < 7);
        end
        steady = 1'b0;
        mac(rand_fp(), 4'($urandom), 1'b1);
    endtask

    always @(posedge clk)
        results.ready <= steady || $urandom_range(0, 99) >= IdlePct;

    always @(posedge clk)
    begin
        if (items.valid && items.ready)
            sb.note_item(items.command,
                         {items.rhs_pair_7, items.rhs_pair_6, items.rhs_pair_5,
                          items.rhs_pair_4, items.rhs_pair_3, items.rhs_pair_2,
                          items.rhs_pair_1, items.rhs_pair_0},
                         items.lhs_value, items.row_index, items.end_of_tile);
        if (results.valid && results.ready)
            sb.check_row(results.out_row,
                         {results.sum_pair_7, results.sum_pair_6, results.sum_pair_5,
                          results.sum_pair_4, results.sum_pair_3, results.sum_pair_2,
                          results.sum_pair_1, results.sum_pair_0},
                         results.last_row);
    end

    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready) || !rst_n)
            stalled <= 0;
        else
            stalled <= stalled + 1;
        if (stalled >= StallLimit)
        begin
            $display("tile_outer_product_accumulator verification failed");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        steady = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        items.valid = 1'b0;
        items.command = CMD_LOAD;
        {items.rhs_pair_0, items.rhs_pair_1, items.rhs_pair_2, items.rhs_pair_3} = '0;
        {items.rhs_pair_4, items.rhs_pair_5, items.rhs_pair_6, items.rhs_pair_7} = '0;
        items.lhs_value = '0;
        items.row_index = '0;
        items.end_of_tile = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        items.valid <= 1'b0;
        // hold off until the directed tile has drained
        while (sb.pending() != 0)
            @(posedge clk);
        random_items(240);
        items.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("tile_outer_product_accumulator verification clean");
        else
            $display("tile_outer_product_accumulator verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/topa_pkg.sv
design/topa_if.sv
design/topa_fma.sv
design/topa_datapath.sv
design/topa_ctrl.sv
design/tile_outer_product_accumulator.sv
tb/sv/topa_tb_pkg.sv
tb/sv/tb_top.sv
